FILE: rtl/mte_pkg.sv
// Shared types, codes and helpers of the motif transition estimator.
// No dependencies; every other file that uses this package refers to it by scoped names.
package mte_pkg;

    localparam int MAX_TYPES  = 4;
    localparam int COUNT_BITS = 16;
    localparam int ADDR_W     = 5;
    localparam int NUM_SLOTS  = 24;
    localparam int PRIOR_W    = 20;
    localparam int WEIGHT_W   = 16;
    localparam int PROD_C_W   = 33;
    localparam int PROD_P_W   = 36;
    localparam int VAL_W      = 41;
    localparam int SUM_W      = 43;
    localparam int REM_W      = 44;
    localparam int PROB_W     = 17;
    localparam int DIV_STEPS  = 16;

    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_SITE    = 2'd1;
    localparam logic [1:0] REQ_END     = 2'd2;
    localparam logic [1:0] REQ_COMPUTE = 2'd3;

    localparam logic [1:0] KIND_TRANS = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_BEGIN = 2'd2;

    localparam logic [1:0] CFG_ACTIVE_TYPES = 2'd0;
    localparam logic [1:0] CFG_PRIOR_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_SYMMETRIC    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ACC,
        S_DIV_LD,
        S_DIV,
        S_DIV_WR,
        S_RD_A,
        S_RD_B,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic              ev_load;
        logic              ev_site;
        logic              ev_end;
        logic              sum_clr;
        logic              rd_prior;
        logic              mul;
        logic              acc;
        logic              div_load;
        logic              div_step;
        logic              div_write;
        logic              rd_a;
        logic              rd_b;
        logic              out_load;
        logic              clear;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] taddr;
        logic [1:0]        elem;
        logic              sym_pair;
        logic [1:0]        out_kind;
        logic [1:0]        out_row;
        logic [1:0]        out_col;
        logic              out_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] nm1;
        logic       out_free;
    } status_t;

    // Slot layout: transitions at row*4+col, end at 16+row, begin at 20+row.
    function automatic logic [ADDR_W-1:0] make_addr(logic [1:0] kind, logic [1:0] row,
                                                   logic [1:0] col);
        logic [ADDR_W-1:0] a;
        if (kind == KIND_TRANS)
        begin
            a = {1'b0, row, col};
        end
        else
        begin
            a = {1'b1, 1'b0, (kind == KIND_BEGIN), row};
        end
        return a;
    endfunction

endpackage

FILE: rtl/mte_in_if.sv
// Input channel of the motif transition estimator: valid/ready plus request fields.
// Depends on nothing.
interface mte_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  prior_kind;
    logic [1:0]  row_index;
    logic [1:0]  col_index;
    logic [19:0] prior_value;

    modport source (output valid, req_type, prior_kind, row_index, col_index, prior_value,
                    input ready);
    modport sink (input valid, req_type, prior_kind, row_index, col_index, prior_value,
                  output ready);
endinterface

FILE: rtl/mte_out_if.sv
// Result channel of the motif transition estimator: valid/ready plus probability fields.
// Depends on nothing.
interface mte_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  prob_kind;
    logic [1:0]  prob_row;
    logic [1:0]  prob_col;
    logic [16:0] probability;
    logic        last_result;

    modport source (output valid, prob_kind, prob_row, prob_col, probability, last_result,
                    input ready);
    modport sink (input valid, prob_kind, prob_row, prob_col, probability, last_result,
                  output ready);
endinterface

FILE: rtl/mte_ctrl.sv
// Sequencer of the estimator: decodes requests and steps the datapath through
// accumulate, divide and emit passes. Depends on mte_pkg.
module mte_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        in_req,
    input  mte_pkg::status_t  status,
    output mte_pkg::cmd_t     cmd
);

    mte_pkg::state_t state_reg, state_next;
    logic [1:0] kind_reg, kind_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] elem_reg, elem_next;
    logic [3:0] step_reg, step_next;
    logic       last_elem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mte_pkg::S_IDLE;
            kind_reg  <= mte_pkg::KIND_TRANS;
            row_reg   <= '0;
            elem_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            row_reg   <= row_next;
            elem_reg  <= elem_next;
            step_reg  <= step_next;
        end
    end

    assign last_elem = (elem_reg == status.nm1);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        row_next   = row_reg;
        elem_next  = elem_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        // end and begin vectors are indexed by the element
        cmd.addr   = (kind_reg == mte_pkg::KIND_TRANS)
                     ? mte_pkg::make_addr(kind_reg, row_reg, elem_reg)
                     : mte_pkg::make_addr(kind_reg, elem_reg, 2'd0);
        cmd.taddr  = mte_pkg::make_addr(kind_reg, elem_reg, row_reg);
        cmd.elem   = elem_reg;
        cmd.sym_pair = (kind_reg == mte_pkg::KIND_TRANS) && (row_reg != elem_reg);
        cmd.out_kind = kind_reg;
        cmd.out_row  = (kind_reg == mte_pkg::KIND_TRANS) ? row_reg : elem_reg;
        cmd.out_col  = (kind_reg == mte_pkg::KIND_TRANS) ? elem_reg : 2'd0;
        cmd.out_last = (kind_reg == mte_pkg::KIND_BEGIN) && last_elem;

        unique case (state_reg)
            mte_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_req)
                        mte_pkg::REQ_LOAD: cmd.ev_load = 1'b1;
                        mte_pkg::REQ_SITE: cmd.ev_site = 1'b1;
                        mte_pkg::REQ_END:  cmd.ev_end  = 1'b1;
                        mte_pkg::REQ_COMPUTE:
                        begin
                            cmd.sum_clr = 1'b1;
                            kind_next   = mte_pkg::KIND_TRANS;
                            row_next    = '0;
                            elem_next   = '0;
                            state_next  = mte_pkg::S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            mte_pkg::S_RD:
            begin
                cmd.rd_prior = 1'b1;
                state_next   = mte_pkg::S_MUL;
            end
            mte_pkg::S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = mte_pkg::S_ACC;
            end
            mte_pkg::S_ACC:
            begin
                cmd.acc = 1'b1;
                if (last_elem)
                begin
                    elem_next  = '0;
                    state_next = mte_pkg::S_DIV_LD;
                end
                else
                begin
                    elem_next  = elem_reg + 2'd1;
                    state_next = mte_pkg::S_RD;
                end
            end
            mte_pkg::S_DIV_LD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = mte_pkg::S_DIV;
            end
            mte_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 4'd1;
                if (step_reg == 4'(mte_pkg::DIV_STEPS - 1))
                begin
                    state_next = mte_pkg::S_DIV_WR;
                end
            end
            mte_pkg::S_DIV_WR:
            begin
                cmd.div_write = 1'b1;
                if (!last_elem)
                begin
                    elem_next  = elem_reg + 2'd1;
                    state_next = mte_pkg::S_DIV_LD;
                end
                else
                begin
                    // advance to the next row or vector, or to the emit pass after the begin vector
                    elem_next   = '0;
                    cmd.sum_clr = 1'b1;
                    state_next  = mte_pkg::S_RD;
                    priority if (kind_reg == mte_pkg::KIND_TRANS && row_reg != status.nm1)
                    begin
                        row_next = row_reg + 2'd1;
                    end
                    else if (kind_reg == mte_pkg::KIND_TRANS)
                    begin
                        kind_next = mte_pkg::KIND_END;
                        row_next  = '0;
                    end
                    else if (kind_reg == mte_pkg::KIND_END)
                    begin
                        kind_next = mte_pkg::KIND_BEGIN;
                    end
                    else
                    begin
                        kind_next  = mte_pkg::KIND_TRANS;
                        row_next   = '0;
                        state_next = mte_pkg::S_RD_A;
                    end
                end
            end
            mte_pkg::S_RD_A:
            begin
                cmd.rd_a   = 1'b1;
                state_next = mte_pkg::S_RD_B;
            end
            mte_pkg::S_RD_B:
            begin
                cmd.rd_b   = 1'b1;
                state_next = mte_pkg::S_EMIT;
            end
            mte_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = mte_pkg::S_RD_A;
                    if (!last_elem)
                    begin
                        elem_next = elem_reg + 2'd1;
                    end
                    else
                    begin
                        elem_next = '0;
                        priority if (kind_reg == mte_pkg::KIND_TRANS && row_reg != status.nm1)
                        begin
                            row_next = row_reg + 2'd1;
                        end
                        else if (kind_reg == mte_pkg::KIND_TRANS)
                        begin
                            kind_next = mte_pkg::KIND_END;
                            row_next  = '0;
                        end
                        else if (kind_reg == mte_pkg::KIND_END)
                        begin
                            kind_next = mte_pkg::KIND_BEGIN;
                        end
                        else
                        begin
                            kind_next  = mte_pkg::KIND_TRANS;
                            cmd.clear  = 1'b1;
                            state_next = mte_pkg::S_IDLE;
                        end
                    end
                end
            end
            default: state_next = mte_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: rtl/mte_datapath.sv
// Datapath of the estimator: config registers, counters, prior and result memories,
// weighting multipliers, restoring divider and the output register. Depends on mte_pkg.
module mte_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [1:0]        in_kind,
    input  logic [1:0]        in_row,
    input  logic [1:0]        in_col,
    input  logic [19:0]       in_value,
    input  mte_pkg::cmd_t     cmd,
    output mte_pkg::status_t  status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        out_kind,
    output logic [1:0]        out_row,
    output logic [1:0]        out_col,
    output logic [16:0]       out_prob,
    output logic              out_last
);

    logic [2:0]  active_reg;
    logic [15:0] weight_reg;
    logic        sym_reg;

    logic [mte_pkg::COUNT_BITS-1:0] cnt_reg [mte_pkg::NUM_SLOTS];
    logic                           prev_valid_reg;
    logic [1:0]                     prev_type_reg;

    logic [mte_pkg::PRIOR_W-1:0]    prior_mem [mte_pkg::NUM_SLOTS];
    logic [mte_pkg::PROB_W-1:0]     res_mem [mte_pkg::NUM_SLOTS];

    logic [mte_pkg::PRIOR_W-1:0]    prior_q_reg;
    logic [mte_pkg::COUNT_BITS-1:0] cnt_q_reg;
    logic [mte_pkg::PROD_C_W-1:0]   pc_reg;
    logic [mte_pkg::PROD_P_W-1:0]   pp_reg;
    logic [mte_pkg::VAL_W-1:0]      val_reg [mte_pkg::MAX_TYPES];
    logic [mte_pkg::SUM_W-1:0]      sum_reg;
    logic [mte_pkg::REM_W-1:0]      rem_reg;
    logic [mte_pkg::PROB_W-1:0]     quo_reg;
    logic [mte_pkg::PROB_W-1:0]     rd_q_reg;
    logic [mte_pkg::PROB_W-1:0]     a_q_reg;

    logic                           out_valid_reg;
    logic [1:0]                     out_kind_reg, out_row_reg, out_col_reg;
    logic [mte_pkg::PROB_W-1:0]     out_prob_reg;
    logic                           out_last_reg;

    logic [1:0]                     nm1;
    logic [mte_pkg::ADDR_W-1:0]     load_addr;
    logic [mte_pkg::ADDR_W-1:0]     inc_addr;
    logic                           inc_en;
    logic [mte_pkg::VAL_W-1:0]      val_new;
    logic [mte_pkg::REM_W-1:0]      sum_ext;
    logic [mte_pkg::REM_W-1:0]      val_ext;
    logic [mte_pkg::REM_W-1:0]      rem_sh;
    logic [mte_pkg::REM_W:0]        rem_dbl;
    logic [mte_pkg::PROB_W-1:0]     result;
    logic [mte_pkg::PROB_W:0]       avg_sum;

    // clamp active types to 1..MAX_TYPES
    always_comb
    begin
        priority if (active_reg == 3'd0)
        begin
            nm1 = 2'd0;
        end
        else if (active_reg > 3'(mte_pkg::MAX_TYPES))
        begin
            nm1 = 2'(mte_pkg::MAX_TYPES - 1);
        end
        else
        begin
            nm1 = 2'(active_reg - 3'd1);
        end
    end

    assign status.nm1      = nm1;
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 3'd4;
            weight_reg <= 16'd32768;
            sym_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mte_pkg::CFG_ACTIVE_TYPES: active_reg <= cfg_data[2:0];
                mte_pkg::CFG_PRIOR_WEIGHT: weight_reg <= cfg_data;
                mte_pkg::CFG_SYMMETRIC:    sym_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // event counting
    always_comb
    begin
        inc_en   = 1'b0;
        inc_addr = mte_pkg::make_addr(mte_pkg::KIND_BEGIN, in_row, 2'd0);
        if (cmd.ev_site && in_row <= nm1)
        begin
            inc_en = 1'b1;
            if (prev_valid_reg)
            begin
                inc_addr = mte_pkg::make_addr(mte_pkg::KIND_TRANS, in_row, prev_type_reg);
            end
        end
        else if (cmd.ev_end && prev_valid_reg)
        begin
            inc_en   = 1'b1;
            inc_addr = mte_pkg::make_addr(mte_pkg::KIND_END, prev_type_reg, 2'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mte_pkg::NUM_SLOTS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            prev_valid_reg <= 1'b0;
            prev_type_reg  <= '0;
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < mte_pkg::NUM_SLOTS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            prev_valid_reg <= 1'b0;
            prev_type_reg  <= '0;
        end
        else
        begin
            if (inc_en && cnt_reg[inc_addr] != '1)
            begin
                cnt_reg[inc_addr] <= cnt_reg[inc_addr] + 1'b1;
            end
            if (cmd.ev_site && in_row <= nm1)
            begin
                prev_valid_reg <= 1'b1;
                prev_type_reg  <= in_row;
            end
            else if (cmd.ev_end)
            begin
                prev_valid_reg <= 1'b0;
                prev_type_reg  <= '0;
            end
        end
    end

    assign load_addr = mte_pkg::make_addr(in_kind, in_row, in_col);

    always_ff @(posedge clk)
    begin
        if (cmd.ev_load && in_kind != 2'd3)
        begin
            prior_mem[load_addr] <= in_value;
        end
        if (cmd.rd_prior)
        begin
            prior_q_reg <= prior_mem[cmd.addr];
        end
    end

    // weighting: (65536 - w) * count * 256 + w * prior
    assign val_new = {pc_reg, 8'd0} + mte_pkg::VAL_W'(pp_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.rd_prior)
        begin
            cnt_q_reg <= cnt_reg[cmd.addr];
        end
        if (cmd.mul)
        begin
            pc_reg <= (17'h10000 - {1'b0, weight_reg}) * cnt_q_reg;
            pp_reg <= weight_reg * prior_q_reg;
        end
        if (cmd.acc)
        begin
            val_reg[cmd.elem] <= val_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.acc)
        begin
            sum_reg <= sum_reg + mte_pkg::SUM_W'(val_new);
        end
    end

    // restoring divider, one quotient bit a cycle
    assign sum_ext = mte_pkg::REM_W'(sum_reg);
    assign val_ext = mte_pkg::REM_W'(val_reg[cmd.elem]);
    assign rem_sh  = {rem_reg[mte_pkg::REM_W-2:0], 1'b0};
    assign rem_dbl = {rem_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            if (val_ext >= sum_ext)
            begin
                rem_reg <= val_ext - sum_ext;
                quo_reg <= mte_pkg::PROB_W'(1);
            end
            else
            begin
                rem_reg <= val_ext;
                quo_reg <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= sum_ext)
            begin
                rem_reg <= rem_sh - sum_ext;
                quo_reg <= {quo_reg[mte_pkg::PROB_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[mte_pkg::PROB_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        if (sum_reg == '0)
        begin
            result = '0;
        end
        else if (rem_dbl >= {1'b0, sum_ext})
        begin
            result = quo_reg + 1'b1;
        end
        else
        begin
            result = quo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_write)
        begin
            res_mem[cmd.addr] <= result;
        end
        if (cmd.rd_a)
        begin
            rd_q_reg <= res_mem[cmd.addr];
        end
        else if (cmd.rd_b)
        begin
            rd_q_reg <= res_mem[cmd.taddr];
            a_q_reg  <= rd_q_reg;
        end
    end

    assign avg_sum = {1'b0, a_q_reg} + {1'b0, rd_q_reg} + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_kind;
            out_row_reg  <= cmd.out_row;
            out_col_reg  <= cmd.out_col;
            out_last_reg <= cmd.out_last;
            out_prob_reg <= (sym_reg && cmd.sym_pair) ? avg_sum[mte_pkg::PROB_W:1] : a_q_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_prob  = out_prob_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: rtl/motif_transition_estimator_core.sv
// Motif transition estimator: counts motif-site events and turns them into
// normalized probabilities. Uses mte_pkg, mte_in_if, mte_out_if, mte_ctrl, mte_datapath.
//
// Usage:
//   in_ch carries requests: prior loads, site starts, sequence ends, compute.
//   Loads and events are taken one per cycle while the block is idle.
//   A compute request emits n*n transition, n end and n begin probabilities
//   on out_ch, with last_result on the final one; n is the active type count.
//   Compute pass: each of the n+2 rows is weighted and summed, then goes through
//   the bit-serial restoring divider (17 quotient steps plus the write); then each
//   result is read from the result memory and loaded into the output register.
//   A stall on out_ch holds the emit pass.
//   in_ch stays not ready from the compute transfer until the last result
//   has been loaded into the output register; counts then clear, priors stay.
//   Configuration is written on cfg_we/cfg_index/cfg_data; the user must do this
//   only while idle, as the block does not enforce it. Reset clears counts and
//   restores default configuration; priors must be loaded before the first compute.
module motif_transition_estimator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    mte_in_if.sink      in_ch,
    mte_out_if.source   out_ch
);

    mte_pkg::cmd_t    cmd;
    mte_pkg::status_t status;

    mte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_req   (in_ch.req_type),
        .status   (status),
        .cmd      (cmd)
    );

    mte_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_kind   (in_ch.prior_kind),
        .in_row    (in_ch.row_index),
        .in_col    (in_ch.col_index),
        .in_value  (in_ch.prior_value),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_kind  (out_ch.prob_kind),
        .out_row   (out_ch.prob_row),
        .out_col   (out_ch.prob_col),
        .out_prob  (out_ch.probability),
        .out_last  (out_ch.last_result)
    );

endmodule

FILE: verif/tb.sv
// Self-checking testbench of motif_transition_estimator_core: prior loads, site
// events and compute passes checked result by result. Uses mte_pkg, mte_in_if, mte_out_if.
module tb;

    typedef struct packed {
        logic [1:0]  req;
        logic [1:0]  kind;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [19:0] val;
        logic        all_zero;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [16:0] prob;
        logic        last;
    } prob_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    mte_in_if  in_ch();
    mte_out_if out_ch();

    motif_transition_estimator_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
    );

    // Predictor state
    logic [2:0]  m_active;
    logic [15:0] m_weight;
    logic        m_sym;
    logic [15:0] trans_cnt [4][4];
    logic [15:0] end_cnt [4];
    logic [15:0] begin_cnt [4];
    logic [19:0] trans_prior [4][4];
    logic [19:0] end_prior [4];
    logic [19:0] begin_prior [4];
    logic        prev_ok;
    logic [1:0]  prev_t;

    prob_t expected_probs[$];
    int n_err;
    bit gaps_on;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint unsigned weigh(logic [15:0] c, logic [19:0] p);
        longint unsigned w;
        w = m_weight;
        return (65536 - w) * c * 256 + w * p;
    endfunction

    function automatic logic [16:0] ratio(longint unsigned x, longint unsigned s);
        longint unsigned q;
        longint unsigned r;
        if (s == 0)
        begin
            return 17'd0;
        end
        q = (x << 16) / s;
        r = (x << 16) % s;
        if (2 * r >= s)
        begin
            q = q + 1;
        end
        return q[16:0];
    endfunction

    function automatic void clear_counts();
        for (int i = 0; i < 4; i++)
        begin
            end_cnt[i] = '0;
            begin_cnt[i] = '0;
            for (int j = 0; j < 4; j++)
            begin
                trans_cnt[i][j] = '0;
            end
        end
        prev_ok = 1'b0;
        prev_t = '0;
    endfunction

    function automatic void bump(ref logic [15:0] c);
        if (c != 16'hFFFF)
        begin
            c = c + 1'b1;
        end
    endfunction

    function automatic void predict_compute(logic all_zero);
        int n;
        longint unsigned v [4];
        longint unsigned s;
        logic [16:0] tp [4][4];
        logic [16:0] ep [4];
        logic [16:0] bp [4];
        logic [16:0] a;
        prob_t r;
        n = (m_active == 0) ? 1
                            : ((m_active > mte_pkg::MAX_TYPES) ? mte_pkg::MAX_TYPES : m_active);
        for (int t = 0; t < n; t++)
        begin
            s = 0;
            for (int u = 0; u < n; u++)
            begin
                v[u] = weigh(trans_cnt[t][u], trans_prior[t][u]);
                s += v[u];
            end
            for (int u = 0; u < n; u++)
            begin
                tp[t][u] = ratio(v[u], s);
            end
        end
        if (m_sym)
        begin
            for (int t = 0; t < n; t++)
            begin
                for (int u = t + 1; u < n; u++)
                begin
                    a = 17'((18'(tp[t][u]) + 18'(tp[u][t]) + 18'd1) >> 1);
                    tp[t][u] = a;
                    tp[u][t] = a;
                end
            end
        end
        s = 0;
        for (int t = 0; t < n; t++)
        begin
            v[t] = weigh(end_cnt[t], end_prior[t]);
            s += v[t];
        end
        for (int t = 0; t < n; t++)
        begin
            ep[t] = ratio(v[t], s);
        end
        s = 0;
        for (int t = 0; t < n; t++)
        begin
            v[t] = weigh(begin_cnt[t], begin_prior[t]);
            s += v[t];
        end
        for (int t = 0; t < n; t++)
        begin
            bp[t] = ratio(v[t], s);
        end
        for (int t = 0; t < n; t++)
        begin
            for (int u = 0; u < n; u++)
            begin
                r = '{mte_pkg::KIND_TRANS, t[1:0], u[1:0], all_zero ? 17'd0 : tp[t][u], 1'b0};
                expected_probs.push_back(r);
            end
        end
        for (int t = 0; t < n; t++)
        begin
            r = '{mte_pkg::KIND_END, t[1:0], 2'd0, all_zero ? 17'd0 : ep[t], 1'b0};
            expected_probs.push_back(r);
        end
        for (int t = 0; t < n; t++)
        begin
            r = '{mte_pkg::KIND_BEGIN, t[1:0], 2'd0, all_zero ? 17'd0 : bp[t], t == n - 1};
            expected_probs.push_back(r);
        end
        clear_counts();
    endfunction

    function automatic void predict(req_t q);
        int n;
        n = (m_active == 0) ? 1
                            : ((m_active > mte_pkg::MAX_TYPES) ? mte_pkg::MAX_TYPES : m_active);
        case (q.req)
            mte_pkg::REQ_LOAD:
            begin
                if (q.kind == mte_pkg::KIND_TRANS)
                begin
                    trans_prior[q.row][q.col] = q.val;
                end
                else if (q.kind == mte_pkg::KIND_END)
                begin
                    end_prior[q.row] = q.val;
                end
                else if (q.kind == mte_pkg::KIND_BEGIN)
                begin
                    begin_prior[q.row] = q.val;
                end
            end
            mte_pkg::REQ_SITE:
            begin
                if (q.row < n)
                begin
                    if (prev_ok)
                    begin
                        bump(trans_cnt[q.row][prev_t]);
                    end
                    else
                    begin
                        bump(begin_cnt[q.row]);
                    end
                    prev_ok = 1'b1;
                    prev_t = q.row;
                end
            end
            mte_pkg::REQ_END:
            begin
                if (prev_ok)
                begin
                    bump(end_cnt[prev_t]);
                end
                prev_ok = 1'b0;
                prev_t = '0;
            end
            default:
            begin
                predict_compute(q.all_zero);
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int p;
        if (!gaps_on)
        begin
            return 0;
        end
        p = $urandom_range(99);
        if (p < 60)
        begin
            return 0;
        end
        if (p < 92)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    task automatic send(req_t q);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.req_type    <= q.req;
        in_ch.prior_kind  <= q.kind;
        in_ch.row_index   <= q.row;
        in_ch.col_index   <= q.col;
        in_ch.prior_value <= q.val;
        in_ch.valid       <= 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        predict(q);
    endtask

    task automatic send_fields(logic [1:0] rq, logic [1:0] k, logic [1:0] r, logic [1:0] c,
                               logic [19:0] v);
        req_t q;
        q = '{rq, k, r, c, v, 1'b0};
        send(q);
    endtask

    // Drop valid, drain every expected result, then let the block settle.
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (expected_probs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] d);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mte_pkg::CFG_ACTIVE_TYPES: m_active = d[2:0];
            mte_pkg::CFG_PRIOR_WEIGHT: m_weight = d;
            default:                   m_sym = d[0];
        endcase
    endtask

    task automatic load_priors(bit zero);
        logic [19:0] v;
        for (int k = 0; k < 3; k++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < ((k == 0) ? 4 : 1); c++)
                begin
                    case ($urandom_range(5))
                        0:       v = 20'h00000;
                        1:       v = 20'hFFFFF;
                        default: v = $urandom_range(20'hFFFFF);
                    endcase
                    if (zero)
                    begin
                        v = '0;
                    end
                    send_fields(mte_pkg::REQ_LOAD, k[1:0], r[1:0], c[1:0], v);
                end
            end
        end
    endtask

    // Result side: random stalls, compare each transfer with the oldest expectation.
    int stall_left;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (gaps_on && $urandom_range(3) == 0)
            begin
                stall_left <= ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                       : $urandom_range(3, 1);
            end
        end
    end

    always @(posedge clk)
    begin
        prob_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_probs.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                begin
                    $display("unexpected result kind %0d row %0d col %0d p %0d",
                             out_ch.prob_kind, out_ch.prob_row, out_ch.prob_col,
                             out_ch.probability);
                end
            end
            else
            begin
                e = expected_probs.pop_front();
                if (out_ch.prob_kind !== e.kind || out_ch.prob_row !== e.row ||
                    out_ch.prob_col !== e.col || out_ch.probability !== e.prob ||
                    out_ch.last_result !== e.last)
                begin
                    n_err++;
                    if (n_err <= 10)
                    begin
                        $display("mismatch exp k%0d r%0d c%0d p%0d l%0d got k%0d r%0d c%0d p%0d l%0d",
                                 e.kind, e.row, e.col, e.prob, e.last,
                                 out_ch.prob_kind, out_ch.prob_row, out_ch.prob_col,
                                 out_ch.probability, out_ch.last_result);
                    end
                end
            end
        end
    end

    req_t directed [16] = '{
        '{mte_pkg::REQ_COMPUTE, 2'd0, 2'd0, 2'd0, 20'h0, 1'b1},
        '{mte_pkg::REQ_LOAD, 2'd3, 2'd0, 2'd0, 20'hFFFFF, 1'b0},
        '{mte_pkg::REQ_END, 2'd0, 2'd0, 2'd0, 20'h0, 1'b0},
        '{mte_pkg::REQ_COMPUTE, 2'd0, 2'd0, 2'd0, 20'h0, 1'b1},
        '{mte_pkg::REQ_LOAD, mte_pkg::KIND_TRANS, 2'd3, 2'd3, 20'hFFFFF, 1'b0},
        '{mte_pkg::REQ_LOAD, mte_pkg::KIND_END, 2'd3, 2'd0, 20'h00001, 1'b0},
        '{mte_pkg::REQ_LOAD, mte_pkg::KIND_BEGIN, 2'd0, 2'd3, 20'hFFFFF, 1'b0},
        '{mte_pkg::REQ_SITE, 2'd0, 2'd0, 2'd0, 20'h0, 1'b0},
        '{mte_pkg::REQ_SITE, 2'd0, 2'd3, 2'd0, 20'h0, 1'b0},
        '{mte_pkg::REQ_SITE, 2'd0, 2'd3, 2'd0, 20'h0, 1'b0},
        '{mte_pkg::REQ_SITE, 2'd0, 2'd1, 2'd0, 20'h0, 1'b0},
        '{mte_pkg::REQ_END, 2'd0, 2'd0, 2'd0, 20'h0, 1'b0},
        '{mte_pkg::REQ_SITE, 2'd2, 2'd2, 2'd1, 20'h0, 1'b0},
        '{mte_pkg::REQ_END, 2'd0, 2'd0, 2'd0, 20'h0, 1'b0},
        '{mte_pkg::REQ_END, 2'd0, 2'd0, 2'd0, 20'h0, 1'b0},
        '{mte_pkg::REQ_COMPUTE, 2'd0, 2'd0, 2'd0, 20'h0, 1'b0}
    };

    logic [2:0]  phase_active [8] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd4, 3'd4};
    logic [15:0] phase_weight [8] = '{16'd32768, 16'd0, 16'd65535, 16'd12345,
                                      16'd40000, 16'd1, 16'd65535, 16'd0};

    initial
    begin
        int p;
        int len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.req_type = '0;
        in_ch.prior_kind = '0;
        in_ch.row_index = '0;
        in_ch.col_index = '0;
        in_ch.prior_value = '0;
        out_ch.ready = 1'b0;
        stall_left = 0;
        n_err = 0;
        gaps_on = 1'b1;
        m_active = 3'd4;
        m_weight = 16'd32768;
        m_sym = 1'b0;
        clear_counts();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_priors(1'b1);
        foreach (directed[i])
        begin
            send(directed[i]);
        end
        settle();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(mte_pkg::CFG_ACTIVE_TYPES, {13'd0, phase_active[ph]});
            write_reg(mte_pkg::CFG_PRIOR_WEIGHT, (ph == 4) ? 16'($urandom_range(65535))
                                                           : phase_weight[ph]);
            write_reg(mte_pkg::CFG_SYMMETRIC, {15'd0, ph[0]});
            gaps_on = (ph != 6);
            if (ph[1:0] == 2'd0)
            begin
                load_priors(1'b0);
            end
            for (int it = 0; it < 5; it++)
            begin
                p = $urandom_range(99);
                if (p < 75)
                begin
                    len = $urandom_range(4, 1);
                    repeat (len) send_fields(mte_pkg::REQ_SITE, 2'($urandom_range(3)),
                                             2'($urandom_range(3)), 2'($urandom_range(3)),
                                             20'($urandom_range(20'hFFFFF)));
                    send_fields(mte_pkg::REQ_END, 2'($urandom_range(3)),
                                2'($urandom_range(3)), 2'($urandom_range(3)),
                                20'($urandom_range(20'hFFFFF)));
                end
                else if (p < 88)
                begin
                    send_fields(mte_pkg::REQ_LOAD, 2'($urandom_range(3)),
                                2'($urandom_range(3)), 2'($urandom_range(3)),
                                20'($urandom_range(20'hFFFFF)));
                end
                else if (p < 94)
                begin
                    send_fields(mte_pkg::REQ_SITE, 2'd0, 2'($urandom_range(3)), 2'd0, 20'h0);
                end
                else
                begin
                    send_fields(mte_pkg::REQ_COMPUTE, 2'($urandom_range(3)),
                                2'($urandom_range(3)), 2'($urandom_range(3)),
                                20'($urandom_range(20'hFFFFF)));
                end
            end
            send_fields(mte_pkg::REQ_COMPUTE, 2'd0, 2'd0, 2'd0, 20'h0);
            settle();
        end

        if (n_err == 0 && expected_probs.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
